// File: hdl/countdown_timer_and_alarm_core_defines.svh
// ----------------------------------------------------------------------------
// Countdown timer and alarm core: assertion macros
// Shared assertion forms clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_AND_ALARM_CORE_DEFINES_SVH
`define COUNTDOWN_TIMER_AND_ALARM_CORE_DEFINES_SVH

// Check an implication on every clock edge.
`define CTAA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition at one edge leads to a consequence at the next.
`define CTAA_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

// File: hdl/ctaa_pkg.sv
// ----------------------------------------------------------------------------
// Countdown timer and alarm package
// Opcodes, register indexes, constants and stage types.
// ----------------------------------------------------------------------------
package ctaa_pkg;

    typedef enum logic [2:0] {
        OP_CHECK       = 3'd0,
        OP_SET_TIMER   = 3'd1,
        OP_CANCEL      = 3'd2,
        OP_ALARM_EN    = 3'd3,
        OP_SNOOZE      = 3'd4,
        OP_READ_TIMER  = 3'd5,
        OP_READ_ALARM  = 3'd6
    } op_t;

    typedef enum logic {
        CFG_ALARM_HOUR   = 1'b0,
        CFG_ALARM_MINUTE = 1'b1
    } cfg_idx_t;

    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned CFG_W    = 6;
    localparam int unsigned PROD_W   = 42;

    localparam logic [HOUR_W-1:0]   ALARM_HOUR_RESET   = 5'd7;
    localparam logic [MINUTE_W-1:0] ALARM_MINUTE_RESET = 6'd0;
    localparam logic [9:0]          MS_PER_S           = 10'd1000;
    localparam logic [31:0]         SNOOZE_MS          = 32'd300000;
    localparam logic [31:0]         REFIRE_GUARD_S     = 32'd120;

    typedef struct packed {
        logic [2:0]          op;
        logic [31:0]         now_ms;
        logic [31:0]         timer_ms;
        logic [31:0]         snooze_at;
        logic                alarm_on;
        logic                clock_valid;
        logic [HOUR_W-1:0]   clock_hour;
        logic [MINUTE_W-1:0] clock_minute;
        logic [31:0]         epoch_seconds;
    } stage_t;

    typedef struct packed {
        logic        timer_active;
        logic [31:0] remaining_ms;
        logic        alarm_armed;
        logic        fired_flag;
    } result_t;

endpackage

// File: hdl/ctaa_channels.sv
// ----------------------------------------------------------------------------
// Countdown timer and alarm channels
// Request and response interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ctaa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] now_ms;
    logic [31:0] timer_seconds;
    logic        alarm_on;
    logic        clock_valid;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
    logic [31:0] epoch_seconds;

    modport source (
        output valid, op, now_ms, timer_seconds, alarm_on, clock_valid,
               clock_hour, clock_minute, epoch_seconds,
        input  ready
    );
    modport sink (
        input  valid, op, now_ms, timer_seconds, alarm_on, clock_valid,
               clock_hour, clock_minute, epoch_seconds,
        output ready
    );
endinterface

interface ctaa_rsp_if;
    logic        valid;
    logic        ready;
    logic        timer_active;
    logic [31:0] remaining_ms;
    logic        alarm_armed;
    logic        fired_flag;

    modport source (
        output valid, timer_active, remaining_ms, alarm_armed, fired_flag,
        input  ready
    );
    modport sink (
        input  valid, timer_active, remaining_ms, alarm_armed, fired_flag,
        output ready
    );
endinterface

// File: hdl/countdown_timer_and_alarm_core.sv
// ----------------------------------------------------------------------------
// Countdown timer and alarm core
// Millisecond countdown plus daily alarm with snooze and re-fire guard.
//
//   channel   dir   handshake     payload
//   req       in    valid/ready   op, times, wall clock
//   rsp       out   valid/ready   timer state, remaining ms, armed, flag
//   cfg       in    cfg_we        alarm hour / minute
//
// One request per cycle while the response is not stalled: the request
// register holds the operands (timer product, snooze deadline), and the state
// and the response register update together when that request commits.
// Reset clears both valid bits and all timer and alarm state.
// A stalled response holds both stages; req.ready drops once the request register is full.
// ----------------------------------------------------------------------------
`include "countdown_timer_and_alarm_core_defines.svh"

module countdown_timer_and_alarm_core (
    input  logic                           clk,
    input  logic                           rst_n,
    ctaa_req_if.sink                       req,
    ctaa_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [ctaa_pkg::CFG_W-1:0]     cfg_data
);

    logic [ctaa_pkg::HOUR_W-1:0]   alarm_hour_reg;
    logic [ctaa_pkg::MINUTE_W-1:0] alarm_minute_reg;

    logic        timer_active_reg, timer_active_next;
    logic [31:0] timer_deadline_reg, timer_deadline_next;
    logic        timer_done_reg, timer_done_next;
    logic        alarm_armed_reg, alarm_armed_next;
    logic        alarm_done_reg, alarm_done_next;
    logic [31:0] snooze_deadline_reg, snooze_deadline_next;
    logic [31:0] last_fire_reg, last_fire_next;

    logic                      stage_valid_reg;
    ctaa_pkg::stage_t          stage_reg, stage_next;
    logic                      rsp_valid_reg;
    ctaa_pkg::result_t         rsp_reg, rsp_next;

    logic                      req_ready;
    logic                      advance;
    logic                      commit;
    logic [ctaa_pkg::PROD_W-1:0] timer_prod;

    logic [32:0] set_sum;
    logic        now_lt_deadline;
    logic [31:0] deadline_left;
    logic [32:0] epoch_diff;
    logic        refire_ok;
    logic        snoozed;
    logic        clock_match;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_hour_reg   <= ctaa_pkg::ALARM_HOUR_RESET;
            alarm_minute_reg <= ctaa_pkg::ALARM_MINUTE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (ctaa_pkg::cfg_idx_t'(cfg_index))
                ctaa_pkg::CFG_ALARM_HOUR:
                    alarm_hour_reg <= cfg_data[ctaa_pkg::HOUR_W-1:0];
                ctaa_pkg::CFG_ALARM_MINUTE:
                    alarm_minute_reg <= cfg_data[ctaa_pkg::MINUTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req_ready = !stage_valid_reg || advance;
    assign commit    = stage_valid_reg && advance;
    assign req.ready = req_ready;

    // ---------------- request register ----------------
    assign timer_prod = ctaa_pkg::PROD_W'(req.timer_seconds)
                      * ctaa_pkg::PROD_W'(ctaa_pkg::MS_PER_S);

    always_comb
    begin
        stage_next.op            = req.op;
        stage_next.now_ms        = req.now_ms;
        stage_next.timer_ms      = timer_prod[31:0];
        stage_next.snooze_at     = req.now_ms + ctaa_pkg::SNOOZE_MS;
        stage_next.alarm_on      = req.alarm_on;
        stage_next.clock_valid   = req.clock_valid;
        stage_next.clock_hour    = req.clock_hour;
        stage_next.clock_minute  = req.clock_minute;
        stage_next.epoch_seconds = req.epoch_seconds;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (req_ready)
            stage_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req_ready)
            stage_reg <= stage_next;
    end

    // ---------------- operation ----------------
    assign set_sum         = {1'b0, stage_reg.now_ms} + {1'b0, stage_reg.timer_ms};
    assign now_lt_deadline = stage_reg.now_ms < timer_deadline_reg;
    assign deadline_left   = timer_deadline_reg - stage_reg.now_ms;
    assign epoch_diff      = {1'b0, stage_reg.epoch_seconds} - {1'b0, last_fire_reg};
    assign refire_ok       = !epoch_diff[32] && (epoch_diff[31:0] >= ctaa_pkg::REFIRE_GUARD_S);
    assign snoozed         = (snooze_deadline_reg != 32'd0)
                          && (stage_reg.now_ms < snooze_deadline_reg);
    assign clock_match     = (stage_reg.clock_hour == alarm_hour_reg)
                          && (stage_reg.clock_minute == alarm_minute_reg);

    always_comb
    begin
        timer_active_next    = timer_active_reg;
        timer_deadline_next  = timer_deadline_reg;
        timer_done_next      = timer_done_reg;
        alarm_armed_next     = alarm_armed_reg;
        alarm_done_next      = alarm_done_reg;
        snooze_deadline_next = snooze_deadline_reg;
        last_fire_next       = last_fire_reg;
        rsp_next.fired_flag  = 1'b0;

        unique case (stage_reg.op)
            ctaa_pkg::OP_CHECK:
            begin
                if (timer_active_reg && !now_lt_deadline)
                begin
                    timer_active_next = 1'b0;
                    timer_done_next   = 1'b1;
                end
                if (alarm_armed_reg && !alarm_done_reg && !snoozed)
                begin
                    snooze_deadline_next = 32'd0;
                    if (stage_reg.clock_valid && clock_match && refire_ok)
                    begin
                        last_fire_next  = stage_reg.epoch_seconds;
                        alarm_done_next = 1'b1;
                    end
                end
            end
            ctaa_pkg::OP_SET_TIMER:
            begin
                timer_deadline_next = set_sum[31:0];
                timer_active_next   = 1'b1;
                timer_done_next     = 1'b0;
            end
            ctaa_pkg::OP_CANCEL:
            begin
                timer_active_next = 1'b0;
                timer_done_next   = 1'b0;
            end
            ctaa_pkg::OP_ALARM_EN:
            begin
                alarm_armed_next     = stage_reg.alarm_on;
                alarm_done_next      = 1'b0;
                snooze_deadline_next = 32'd0;
                if (!stage_reg.alarm_on)
                    last_fire_next = 32'd0;
            end
            ctaa_pkg::OP_SNOOZE:
            begin
                alarm_done_next      = 1'b0;
                snooze_deadline_next = stage_reg.snooze_at;
            end
            ctaa_pkg::OP_READ_TIMER:
            begin
                rsp_next.fired_flag = timer_done_reg;
                timer_done_next     = 1'b0;
            end
            ctaa_pkg::OP_READ_ALARM:
            begin
                rsp_next.fired_flag = alarm_done_reg;
                alarm_done_next     = 1'b0;
            end
            default:
            begin
            end
        endcase

        rsp_next.timer_active = timer_active_next;
        rsp_next.alarm_armed  = alarm_armed_next;
        rsp_next.remaining_ms = 32'd0;
        if (stage_reg.op == ctaa_pkg::OP_SET_TIMER)
        begin
            // new deadline lies ahead only if the sum did not wrap
            if (!set_sum[32] && (stage_reg.timer_ms != 32'd0))
                rsp_next.remaining_ms = stage_reg.timer_ms;
        end
        else if (timer_active_next && now_lt_deadline)
        begin
            rsp_next.remaining_ms = deadline_left;
        end
    end

    // ---------------- state and response ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_active_reg    <= 1'b0;
            timer_deadline_reg  <= 32'd0;
            timer_done_reg      <= 1'b0;
            alarm_armed_reg     <= 1'b0;
            alarm_done_reg      <= 1'b0;
            snooze_deadline_reg <= 32'd0;
            last_fire_reg       <= 32'd0;
        end
        else if (commit)
        begin
            timer_active_reg    <= timer_active_next;
            timer_deadline_reg  <= timer_deadline_next;
            timer_done_reg      <= timer_done_next;
            alarm_armed_reg     <= alarm_armed_next;
            alarm_done_reg      <= alarm_done_next;
            snooze_deadline_reg <= snooze_deadline_next;
            last_fire_reg       <= last_fire_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= stage_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            rsp_reg <= rsp_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.timer_active = rsp_reg.timer_active;
    assign rsp.remaining_ms = rsp_reg.remaining_ms;
    assign rsp.alarm_armed  = rsp_reg.alarm_armed;
    assign rsp.fired_flag   = rsp_reg.fired_flag;

    // ---------------- assertions ----------------
    `CTAA_ASSERT(a_done_ends_timer, $rose(timer_done_reg) |-> $fell(timer_active_reg), "timer flag set without expiry")
    `CTAA_ASSERT(a_fire_needs_arm, $rose(alarm_done_reg) |-> alarm_armed_reg, "alarm fired while disarmed")
    `CTAA_ASSERT(a_rem_needs_run, (rsp.valid && (rsp.remaining_ms != 32'd0)) |-> rsp.timer_active, "time left on stopped timer")
    `CTAA_ASSERT_NEXT(a_commit_shows, commit, rsp.valid, "committed request produced no response")

endmodule

// File: bench/tb_countdown_timer_and_alarm_core.sv
// ----------------------------------------------------------------------------
// Countdown timer and alarm core: self-checking bench
// Walks a short table of directed requests, then several phases of random
// requests under different alarm settings and idle patterns. A local model
// of the timer and alarm state predicts every response that the table does
// not give, and each response is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_countdown_timer_and_alarm_core;

    localparam logic [31:0]     MS_IN_S         = 32'd1000;
    localparam logic [31:0]     SNOOZE_SPAN_MS  = 32'd300000;
    localparam longint          REFIRE_GAP_S    = 120;
    localparam ctaa_pkg::op_t   OP_UNUSED       = ctaa_pkg::op_t'(3'd7);
    localparam int              SETTLE_CYCLES   = 4;
    localparam int              TAIL_CYCLES     = 10;
    localparam int              STALL_LIMIT     = 2000;
    localparam int              PHASE_ITEMS     = 220;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    typedef struct {
        ctaa_pkg::op_t op;
        logic [31:0]   now_ms;
        logic [31:0]   timer_seconds;
        logic          alarm_on;
        logic          clock_valid;
        logic [4:0]    clock_hour;
        logic [5:0]    clock_minute;
        logic [31:0]   epoch_seconds;
    } request_t;

    typedef struct {
        request_t          rq;
        bit                typed;
        ctaa_pkg::result_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [ctaa_pkg::CFG_W-1:0] cfg_data;

    ctaa_req_if req ();
    ctaa_rsp_if rsp ();

    countdown_timer_and_alarm_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state
    logic [4:0]  alarm_hour_set;
    logic [5:0]  alarm_minute_set;
    logic        countdown_running;
    logic [31:0] countdown_deadline;
    logic        countdown_fired;
    logic        alarm_enabled;
    logic        alarm_fired;
    logic [31:0] snooze_until;
    logic [31:0] last_alarm_epoch;

    ctaa_pkg::result_t expected_results[$];
    stim_row_t         bus_row;
    stim_row_t         directed_rows[$];
    stim_row_t         accepted_row;
    ctaa_pkg::result_t model_out;
    ctaa_pkg::result_t want;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic [31:0] wall_now = 32'd0;
    logic [31:0] wall_epoch = 32'd10000;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic ctaa_pkg::result_t apply_request(input request_t r);
        ctaa_pkg::result_t res;
        longint            since_fire;
        res = '0;
        case (r.op)
            ctaa_pkg::OP_CHECK:
            begin
                if (countdown_running && r.now_ms >= countdown_deadline)
                begin
                    countdown_running = 1'b0;
                    countdown_fired = 1'b1;
                end
                if (alarm_enabled && !alarm_fired &&
                    !(snooze_until != 32'd0 && r.now_ms < snooze_until))
                begin
                    snooze_until = 32'd0;
                    since_fire = $signed({32'd0, r.epoch_seconds}) -
                                 $signed({32'd0, last_alarm_epoch});
                    if (r.clock_valid && r.clock_hour == alarm_hour_set &&
                        r.clock_minute == alarm_minute_set && since_fire >= REFIRE_GAP_S)
                    begin
                        last_alarm_epoch = r.epoch_seconds;
                        alarm_fired = 1'b1;
                    end
                end
            end
            ctaa_pkg::OP_SET_TIMER:
            begin
                countdown_deadline = r.now_ms + r.timer_seconds * MS_IN_S;
                countdown_running = 1'b1;
                countdown_fired = 1'b0;
            end
            ctaa_pkg::OP_CANCEL:
            begin
                countdown_running = 1'b0;
                countdown_fired = 1'b0;
            end
            ctaa_pkg::OP_ALARM_EN:
            begin
                alarm_enabled = r.alarm_on;
                alarm_fired = 1'b0;
                snooze_until = 32'd0;
                if (!r.alarm_on)
                    last_alarm_epoch = 32'd0;
            end
            ctaa_pkg::OP_SNOOZE:
            begin
                alarm_fired = 1'b0;
                snooze_until = r.now_ms + SNOOZE_SPAN_MS;
            end
            ctaa_pkg::OP_READ_TIMER:
            begin
                res.fired_flag = countdown_fired;
                countdown_fired = 1'b0;
            end
            ctaa_pkg::OP_READ_ALARM:
            begin
                res.fired_flag = alarm_fired;
                alarm_fired = 1'b0;
            end
            default:
            begin
            end
        endcase
        res.timer_active = countdown_running;
        if (countdown_running && r.now_ms < countdown_deadline)
            res.remaining_ms = countdown_deadline - r.now_ms;
        res.alarm_armed = alarm_enabled;
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
        begin
            accepted_row = bus_row;
            model_out = apply_request(accepted_row.rq);
            expected_results.push_back(accepted_row.typed ? accepted_row.want : model_out);
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp.timer_active !== want.timer_active)
                begin
                    $error("timer_active: expected %0d, got %0d", want.timer_active,
                           rsp.timer_active);
                    mismatches++;
                end
                if (rsp.remaining_ms !== want.remaining_ms)
                begin
                    $error("remaining_ms: expected %0d, got %0d", want.remaining_ms,
                           rsp.remaining_ms);
                    mismatches++;
                end
                if (rsp.alarm_armed !== want.alarm_armed)
                begin
                    $error("alarm_armed: expected %0d, got %0d", want.alarm_armed,
                           rsp.alarm_armed);
                    mismatches++;
                end
                if (rsp.fired_flag !== want.fired_flag)
                begin
                    $error("fired_flag: expected %0d, got %0d", want.fired_flag,
                           rsp.fired_flag);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL countdown_timer_and_alarm_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic stim_row_t mk(input ctaa_pkg::op_t op, input logic [31:0] now_ms,
                                     input logic [31:0] secs, input logic on,
                                     input logic valid, input logic [4:0] hr,
                                     input logic [5:0] mn, input logic [31:0] epoch,
                                     input bit typed, input ctaa_pkg::result_t res);
        stim_row_t row;
        row.rq.op = op;
        row.rq.now_ms = now_ms;
        row.rq.timer_seconds = secs;
        row.rq.alarm_on = on;
        row.rq.clock_valid = valid;
        row.rq.clock_hour = hr;
        row.rq.clock_minute = mn;
        row.rq.epoch_seconds = epoch;
        row.typed = typed;
        row.want = res;
        return row;
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t   row;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            wall_now = $urandom();
        else if (pick < 15)
            wall_now += $urandom_range(0, 400000);
        else
            wall_now += $urandom_range(0, 2000);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            wall_epoch = $urandom();
        else if (pick < 7)
            wall_epoch -= $urandom_range(0, 200);
        else
            wall_epoch += $urandom_range(0, 60);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            row.rq.op = ctaa_pkg::OP_CHECK;
        else if (pick < 50)
            row.rq.op = ctaa_pkg::OP_SET_TIMER;
        else if (pick < 55)
            row.rq.op = ctaa_pkg::OP_CANCEL;
        else if (pick < 63)
            row.rq.op = ctaa_pkg::OP_ALARM_EN;
        else if (pick < 73)
            row.rq.op = ctaa_pkg::OP_SNOOZE;
        else if (pick < 83)
            row.rq.op = ctaa_pkg::OP_READ_TIMER;
        else if (pick < 95)
            row.rq.op = ctaa_pkg::OP_READ_ALARM;
        else
            row.rq.op = OP_UNUSED;
        row.rq.now_ms = wall_now;
        row.rq.timer_seconds = ($urandom_range(0, 99) < 8) ? $urandom()
                                                           : $urandom_range(0, 40);
        row.rq.alarm_on = ($urandom_range(0, 99) < 75);
        row.rq.clock_valid = ($urandom_range(0, 99) < 85);
        row.rq.clock_hour = ($urandom_range(0, 99) < 60) ? alarm_hour_set
                                                         : 5'($urandom_range(0, 31));
        row.rq.clock_minute = ($urandom_range(0, 99) < 60) ? alarm_minute_set
                                                           : 6'($urandom_range(0, 63));
        row.rq.epoch_seconds = wall_epoch;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    task automatic send_request(input stim_row_t row);
        bus_row = row;
        req.valid <= 1'b1;
        req.op <= row.rq.op;
        req.now_ms <= row.rq.now_ms;
        req.timer_seconds <= row.rq.timer_seconds;
        req.alarm_on <= row.rq.alarm_on;
        req.clock_valid <= row.rq.clock_valid;
        req.clock_hour <= row.rq.clock_hour;
        req.clock_minute <= row.rq.clock_minute;
        req.epoch_seconds <= row.rq.epoch_seconds;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    task automatic hold_gap();
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_alarm(input logic [4:0] hr, input logic [5:0] mn);
        cfg_we <= 1'b1;
        cfg_index <= ctaa_pkg::CFG_ALARM_HOUR;
        cfg_data <= {1'b0, hr};
        @(negedge clk);
        cfg_index <= ctaa_pkg::CFG_ALARM_MINUTE;
        cfg_data <= mn;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        alarm_hour_set = hr;
        alarm_minute_set = mn;
    endtask

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                send_idle_pct = 46;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 46;
            end
            IDLE_BOTH:
            begin
                send_idle_pct = 14;
                recv_stall_pct = 14;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic run_phase(input logic [4:0] hr, input logic [5:0] mn,
                             input idling_t mode, input bit pause_midway);
        drain();
        program_alarm(hr, mn);
        set_idling(mode);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (pause_midway && i == PHASE_ITEMS / 2)
                drain();
            hold_gap();
            send_request(random_row());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ctaa_pkg::CFG_ALARM_HOUR;
        cfg_data = '0;
        req.valid = 1'b0;
        req.op = ctaa_pkg::OP_CHECK;
        req.now_ms = '0;
        req.timer_seconds = '0;
        req.alarm_on = 1'b0;
        req.clock_valid = 1'b0;
        req.clock_hour = '0;
        req.clock_minute = '0;
        req.epoch_seconds = '0;
        alarm_hour_set = 5'd7;
        alarm_minute_set = 6'd0;
        countdown_running = 1'b0;
        countdown_deadline = '0;
        countdown_fired = 1'b0;
        alarm_enabled = 1'b0;
        alarm_fired = 1'b0;
        snooze_until = '0;
        last_alarm_epoch = '0;

        directed_rows.push_back(mk(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 1,
                                   {1'b0, 32'd0, 1'b0, 1'b0}));
        directed_rows.push_back(mk(ctaa_pkg::OP_READ_TIMER, 0, 0, 0, 0, 0, 0, 0, 1,
                                   {1'b0, 32'd0, 1'b0, 1'b0}));
        directed_rows.push_back(mk(ctaa_pkg::OP_SET_TIMER, 1000, 5, 0, 0, 0, 0, 0, 1,
                                   {1'b1, 32'd5000, 1'b0, 1'b0}));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 5999, 0, 0, 0, 0, 0, 0, 1,
                                   {1'b1, 32'd1, 1'b0, 1'b0}));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 6000, 0, 0, 0, 0, 0, 0, 1,
                                   {1'b0, 32'd0, 1'b0, 1'b0}));
        directed_rows.push_back(mk(ctaa_pkg::OP_READ_TIMER, 6000, 0, 0, 0, 0, 0, 0, 1,
                                   {1'b0, 32'd0, 1'b0, 1'b1}));
        directed_rows.push_back(mk(ctaa_pkg::OP_READ_TIMER, 6000, 0, 0, 0, 0, 0, 0, 1,
                                   {1'b0, 32'd0, 1'b0, 1'b0}));
        directed_rows.push_back(mk(ctaa_pkg::OP_SET_TIMER, 32'hFFFF_FFFF, 1,
                                   0, 0, 0, 0, 0, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 32'hFFFF_FFFF, 0,
                                   0, 0, 0, 0, 0, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_SET_TIMER, 0, 32'hFFFF_FFFF,
                                   0, 0, 0, 0, 0, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 32'hFFFF_FC17, 0,
                                   0, 0, 0, 0, 0, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_CANCEL, 0, 0, 0, 0, 0, 0, 0, 1,
                                   {1'b0, 32'd0, 1'b0, 1'b0}));
        directed_rows.push_back(mk(ctaa_pkg::OP_ALARM_EN, 0, 0, 1, 0, 0, 0, 0, 1,
                                   {1'b0, 32'd0, 1'b1, 1'b0}));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 1000, 0, 0, 1, 7, 0, 1000, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 1000, 0, 0, 1, 7, 0, 1001, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_READ_ALARM, 1000, 0, 0, 1, 7, 0, 1001,
                                   0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 1000, 0, 0, 1, 7, 0, 1100, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 1000, 0, 0, 1, 7, 0, 1120, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_SNOOZE, 1000, 0, 0, 1, 7, 0, 1120, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 300999, 0, 0, 1, 7, 0, 2000, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 301000, 0, 0, 1, 7, 0, 2000, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_SNOOZE, 32'hFFFB_6C20, 0, 0, 1, 7, 0, 2000,
                                   0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 5, 0, 0, 0, 7, 0, 5000, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_CHECK, 6, 0, 0, 1, 7, 0, 100, 0, '0));
        directed_rows.push_back(mk(ctaa_pkg::OP_ALARM_EN, 7, 0, 0, 1, 7, 0, 100, 1,
                                   {1'b0, 32'd0, 1'b0, 1'b0}));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        program_alarm(5'd7, 6'd0);
        set_idling(IDLE_NONE);
        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        run_phase(5'd0, 6'd0, IDLE_NONE, 1'b0);
        run_phase(5'd23, 6'd59, IDLE_SENDER, 1'b0);
        run_phase(5'd31, 6'd63, IDLE_RECEIVER, 1'b0);
        run_phase(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)), IDLE_BOTH, 1'b0);
        run_phase(5'd12, 6'd30, IDLE_NONE, 1'b1);
        run_phase(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)), IDLE_SENDER, 1'b0);
        run_phase(5'd0, 6'd63, IDLE_RECEIVER, 1'b0);
        run_phase(5'd31, 6'd0, IDLE_BOTH, 1'b0);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS countdown_timer_and_alarm_core");
        else
            $display("FAIL countdown_timer_and_alarm_core");
        $finish;
    end

endmodule

// File: countdown_timer_and_alarm_core.f
+incdir+hdl
hdl/ctaa_pkg.sv
hdl/ctaa_channels.sv
hdl/countdown_timer_and_alarm_core.sv
bench/tb_countdown_timer_and_alarm_core.sv
